FILE: rtl/sli_pkg.sv
package sli_pkg;

	// Request beat: operation and signed value.
	typedef struct packed {
		logic               req_type;
		logic signed [31:0] value;
	} sli_req_t;

	// Result beat: status code and entry count after the request.
	typedef struct packed {
		logic [1:0] status;
		logic [4:0] entry_count;
	} sli_rsp_t;

	// Request type codes.
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	// Status codes.
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DELETED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} sli_status_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic signed [31:0] key;
		logic               ins_en;
		logic               del_en;
	} sli_cmd_t;

endpackage

FILE: rtl/sorted_list_insert_delete.sv
// A request is registered into req_s1 and pending_q; the result beat then
// strobes on done from done_q. No request is taken while busy; busy is
// high for the cycle in which the cell row compares and shifts.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset clears the entry count and control state; entries are not cleared.
module sorted_list_insert_delete
	import sli_pkg::*;
#(
	parameter int CAPACITY = 16
)(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sli_req_t req,
	output logic     done,
	output sli_rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

	logic              pending_q;
	sli_req_t          req_s1;
	logic [CW-1:0]     count_q;
	logic              done_q;
	sli_rsp_t          rsp_q;

	logic signed [31:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0] lt_w;
	logic [CAPACITY-1:0] eq_w;
	logic [CAPACITY-1:0] hit_w;
	logic                full;
	logic                found;
	sli_cmd_t            cmd;
	logic [CW-1:0]       count_next;
	sli_status_t         status_next;
	logic [CW+4:0]       count_ext;

	assign busy = pending_q;

	// Request capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else begin
			pending_q <= start && !pending_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !pending_q) begin
			req_s1 <= req;
		end
	end

	// Row of cells; the first cell sees the key on its left.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic signed [31:0] left_e;
		logic               left_l;
		logic signed [31:0] right_e;

		if (i == 0) begin : g_first
			assign left_e = req_s1.value;
			assign left_l = 1'b1;
		end else begin : g_mid
			assign left_e = entry_w[i-1];
			assign left_l = lt_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = entry_w[i];
		end else begin : g_inner
			assign right_e = entry_w[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.valid       (IDX < count_q),
			.left_entry  (left_e),
			.left_lt     (left_l),
			.right_entry (right_e),
			.entry       (entry_w[i]),
			.lt          (lt_w[i]),
			.eq          (eq_w[i])
		);

		// The first cell not below the key holds the match, if any.
		assign hit_w[i] = eq_w[i] && left_l;
	end

	// Decide the operation and the new count.
	assign full  = (count_q == CAP_CW);
	assign found = |hit_w;

	always_comb begin
		cmd.key     = req_s1.value;
		cmd.ins_en  = 1'b0;
		cmd.del_en  = 1'b0;
		count_next  = count_q;
		status_next = ST_INSERTED;
		if (req_s1.req_type == REQ_INSERT) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				cmd.ins_en  = pending_q;
				count_next  = count_q + CW'(1);
				status_next = ST_INSERTED;
			end
		end else begin
			if (found) begin
				cmd.del_en  = pending_q;
				count_next  = count_q - CW'(1);
				status_next = ST_DELETED;
			end else begin
				status_next = ST_NOT_FOUND;
			end
		end
	end

	assign count_ext = {5'd0, count_next};

	// Count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= pending_q;
			if (pending_q) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pending_q) begin
			rsp_q.status      <= status_next;
			rsp_q.entry_count <= count_ext[4:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/sli_cell.sv
module sli_cell
	import sli_pkg::*;
(
	input  logic               clk,
	input  sli_cmd_t           cmd,
	input  logic               valid,
	input  logic signed [31:0] left_entry,
	input  logic               left_lt,
	input  logic signed [31:0] right_entry,
	output logic signed [31:0] entry,
	output logic               lt,
	output logic               eq
);

	logic signed [31:0] entry_q;

	// Local compare against the broadcast key.
	assign lt    = valid && (entry_q < cmd.key);
	assign eq    = valid && (entry_q == cmd.key);
	assign entry = entry_q;

	// Cells at or above the insert point take the key or shift up;
	// on a delete they shift down from the right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !lt) begin
			entry_q <= left_lt ? cmd.key : left_entry;
		end else if (cmd.del_en && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule
